// ===== sv/bpd_pkg.sv =====
package bpd_pkg;

	// field widths
	localparam int LEVEL_W     = 10;
	localparam int SCORE_W     = 8;
	localparam int SHIFT_W     = 4;
	localparam int INTERVAL_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_TUSER_W = 3;

	// score rises by this much per strong sample
	localparam int SCORE_STEP = 4;

	typedef logic [LEVEL_W-1:0]    level_t;
	typedef logic [SCORE_W-1:0]    score_t;
	typedef logic [SHIFT_W-1:0]    shift_t;
	typedef logic [INTERVAL_W-1:0] interval_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FILTER_SHIFT     = 3'd0,
		CFG_DETECT_THRESHOLD = 3'd1,
		CFG_LOST_THRESHOLD   = 3'd2,
		CFG_SCORE_DETECT     = 3'd3,
		CFG_SCORE_LOST       = 3'd4,
		CFG_SCORE_MAX        = 3'd5,
		CFG_REPORT_INTERVAL  = 3'd6,
		CFG_STRENGTH_DELTA   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_SAMPLE_REPORT = 2'd0,
		EV_DETECTED      = 2'd1,
		EV_LOST          = 2'd2,
		EV_STRENGTH      = 2'd3
	} event_kind_t;

	// register reset values
	localparam shift_t    RST_FILTER_SHIFT     = 4'd3;
	localparam level_t    RST_DETECT_THRESHOLD = 10'd40;
	localparam level_t    RST_LOST_THRESHOLD   = 10'd20;
	localparam score_t    RST_SCORE_DETECT     = 8'd16;
	localparam score_t    RST_SCORE_LOST       = 8'd4;
	localparam score_t    RST_SCORE_MAX        = 8'd32;
	localparam interval_t RST_REPORT_INTERVAL  = 16'd100;
	localparam level_t    RST_STRENGTH_DELTA   = 10'd10;

endpackage

// ===== sv/beacon_presence_detector.sv =====
// beacon presence detector
//
// slave stream (s_*) takes one 10-bit detector sample per transaction; the
// master stream (m_*) returns exactly one result transaction per sample,
// carrying an optional event plus the detector's levels and status after
// that sample. registers, written through cfg_we/cfg_index/cfg_data, apply
// from the next sample; the user writes only while the stream is idle (unenforced).
//
// a sample accepted on s_* enters the input register, and its result the
// result register driving m_*. throughput: one sample per cycle while
// m_tready is high; the whole update (filter step, excess, score,
// hysteresis, event priority, and at calibration end one constant multiply
// for the mean) is one combinational pass between the two registers.
//
// after reset (arst_n low) all state is cleared: the first sample only seeds
// the filter and baseline, the next CAL_SAMPLES samples calibrate the
// baseline and the last of them posts a sample report carrying it.
// when m_tready is low the result register holds and s_tready stays high
// only until the input register is also full, so no transaction is lost.
module beacon_presence_detector
	import bpd_pkg::*;
#(
	parameter int CAL_SAMPLES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] sample, rest zero
	// master stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [9:0] event_value, [19:10] raw_level, [29:20] filtered_level,
	// [39:30] baseline_level, [49:40] excess_level, [57:50] confidence,
	// [58] present, [59] calibrated, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] event_valid, [2:1] event_kind
	// register write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// calibration counter and sum widths
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W = LEVEL_W + CNT_W;
	// mean = (sum * RECIP) >> RECIP_SHIFT, exact for every sum below 2^SUM_W
	localparam int RECIP_SHIFT = SUM_W + CNT_W;
	localparam int RECIP_W     = RECIP_SHIFT + 2 - $clog2(CAL_SAMPLES);
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam logic [CNT_W-1:0]   CAL_LAST = CNT_W'(CAL_SAMPLES);

	// configuration registers
	shift_t    filter_shift_q;
	level_t    detect_threshold_q;
	level_t    lost_threshold_q;
	score_t    score_detect_q;
	score_t    score_lost_q;
	score_t    score_max_q;
	interval_t report_interval_q;
	level_t    strength_delta_q;

	// input stage
	logic   s1_valid_q;
	level_t sample_s1;
	logic   advance;

	// detector state, which is also the level/status part of the result
	logic             seeded_q;
	logic             calibrated_q;
	logic [SUM_W-1:0] cal_sum_q;
	logic [CNT_W-1:0] cal_count_q;
	level_t           filtered_q;
	level_t           baseline_q;
	level_t           raw_hold_q;
	level_t           excess_q;
	level_t           last_excess_q;
	interval_t        report_count_q;
	score_t           score_q;
	logic             present_q;

	// event part of the result
	logic        ev_valid_q;
	event_kind_t ev_kind_q;
	level_t      ev_value_q;
	logic        m_tvalid_q;

	// next state
	logic             seeded_n;
	logic             calibrated_n;
	logic [SUM_W-1:0] cal_sum_n;
	logic [CNT_W-1:0] cal_count_n;
	level_t           filtered_n;
	level_t           baseline_n;
	level_t           raw_hold_n;
	level_t           excess_n;
	level_t           last_excess_n;
	interval_t        report_count_n;
	score_t           score_n;
	logic             present_n;
	logic             ev_valid_n;
	event_kind_t      ev_kind_n;
	level_t           ev_value_n;

	// datapath intermediates
	logic              filt_up;
	level_t            filt_mag;
	level_t            filt_step;
	level_t            filt_next;
	logic [SUM_W-1:0]  sum_next;
	logic [CNT_W-1:0]  count_next;
	logic [PROD_W-1:0] cal_prod;
	level_t            cal_mean;
	level_t            exc_calc;
	logic [SCORE_W:0]  score_up;
	logic              now_present;
	interval_t         report_inc;
	level_t            strength_diff;

	// handshake: the input register refills whenever its item moves on
	assign advance  = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (!m_tvalid_q || m_tready) begin
				m_tvalid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[LEVEL_W-1:0];
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_shift_q     <= RST_FILTER_SHIFT;
			detect_threshold_q <= RST_DETECT_THRESHOLD;
			lost_threshold_q   <= RST_LOST_THRESHOLD;
			score_detect_q     <= RST_SCORE_DETECT;
			score_lost_q       <= RST_SCORE_LOST;
			score_max_q        <= RST_SCORE_MAX;
			report_interval_q  <= RST_REPORT_INTERVAL;
			strength_delta_q   <= RST_STRENGTH_DELTA;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FILTER_SHIFT:     filter_shift_q     <= cfg_data[SHIFT_W-1:0];
				CFG_DETECT_THRESHOLD: detect_threshold_q <= cfg_data[LEVEL_W-1:0];
				CFG_LOST_THRESHOLD:   lost_threshold_q   <= cfg_data[LEVEL_W-1:0];
				CFG_SCORE_DETECT:     score_detect_q     <= cfg_data[SCORE_W-1:0];
				CFG_SCORE_LOST:       score_lost_q       <= cfg_data[SCORE_W-1:0];
				CFG_SCORE_MAX:        score_max_q        <= cfg_data[SCORE_W-1:0];
				CFG_REPORT_INTERVAL:  report_interval_q  <= cfg_data[INTERVAL_W-1:0];
				CFG_STRENGTH_DELTA:   strength_delta_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// first-order filter, step truncated toward zero
	assign filt_up   = (sample_s1 >= filtered_q);
	assign filt_mag  = filt_up ? (sample_s1 - filtered_q) : (filtered_q - sample_s1);
	assign filt_step = filt_mag >> filter_shift_q;
	assign filt_next = filt_up ? (filtered_q + filt_step) : (filtered_q - filt_step);

	// calibration accumulate and floored mean by reciprocal multiply
	assign sum_next   = cal_sum_q + SUM_W'(sample_s1);
	assign count_next = cal_count_q + CNT_W'(1);
	assign cal_prod   = PROD_W'(sum_next) * PROD_W'(RECIP);
	assign cal_mean   = cal_prod[RECIP_SHIFT +: LEVEL_W];

	// excess, score and hysteresis terms
	assign exc_calc      = (filt_next > baseline_q) ? (filt_next - baseline_q) : '0;
	assign score_up      = {1'b0, score_q} + (SCORE_W + 1)'(SCORE_STEP);
	assign report_inc    = report_count_q + INTERVAL_W'(1);
	assign strength_diff = (exc_calc > last_excess_q) ? (exc_calc - last_excess_q)
	                                                  : (last_excess_q - exc_calc);

	always_comb begin
		seeded_n       = seeded_q;
		calibrated_n   = calibrated_q;
		cal_sum_n      = cal_sum_q;
		cal_count_n    = cal_count_q;
		filtered_n     = filtered_q;
		baseline_n     = baseline_q;
		raw_hold_n     = raw_hold_q;
		excess_n       = excess_q;
		last_excess_n  = last_excess_q;
		report_count_n = report_count_q;
		score_n        = score_q;
		present_n      = present_q;
		ev_valid_n     = 1'b0;
		ev_kind_n      = EV_SAMPLE_REPORT;
		ev_value_n     = '0;
		now_present    = present_q;

		if (!seeded_q) begin
			// seeding sample
			seeded_n      = 1'b1;
			filtered_n    = sample_s1;
			baseline_n    = sample_s1;
			raw_hold_n    = sample_s1;
			excess_n      = '0;
			last_excess_n = '0;
		end else if (!calibrated_q) begin
			raw_hold_n  = sample_s1;
			filtered_n  = filt_next;
			cal_sum_n   = sum_next;
			cal_count_n = count_next;
			if (count_next >= CAL_LAST) begin
				baseline_n    = cal_mean;
				filtered_n    = cal_mean;
				raw_hold_n    = cal_mean;
				excess_n      = '0;
				last_excess_n = '0;
				score_n       = '0;
				calibrated_n  = 1'b1;
				ev_valid_n    = 1'b1;
				ev_kind_n     = EV_SAMPLE_REPORT;
				ev_value_n    = cal_mean;
			end
		end else begin
			raw_hold_n = sample_s1;
			filtered_n = filt_next;
			excess_n   = exc_calc;

			// detect test wins over lost test
			if (exc_calc >= detect_threshold_q) begin
				score_n = (score_up < {1'b0, score_max_q}) ? score_up[SCORE_W-1:0]
				                                          : score_max_q;
			end else if (exc_calc <= lost_threshold_q) begin
				if (score_q != '0) begin
					score_n = score_q - SCORE_W'(1);
				end
			end

			now_present = present_q ? (score_n > score_lost_q) : (score_n >= score_detect_q);

			if (now_present != present_q) begin
				present_n     = now_present;
				last_excess_n = exc_calc;
				ev_valid_n    = 1'b1;
				ev_kind_n     = now_present ? EV_DETECTED : EV_LOST;
				ev_value_n    = exc_calc;
			end else if (report_inc >= report_interval_q) begin
				report_count_n = '0;
				ev_valid_n     = 1'b1;
				ev_kind_n      = EV_SAMPLE_REPORT;
				ev_value_n     = sample_s1;
			end else begin
				report_count_n = report_inc;
				if (strength_diff >= strength_delta_q) begin
					last_excess_n = exc_calc;
					ev_valid_n    = 1'b1;
					ev_kind_n     = EV_STRENGTH;
					ev_value_n    = exc_calc;
				end
			end
		end
	end

	// state and result register, loaded together when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q       <= 1'b0;
			calibrated_q   <= 1'b0;
			cal_sum_q      <= '0;
			cal_count_q    <= '0;
			filtered_q     <= '0;
			baseline_q     <= '0;
			raw_hold_q     <= '0;
			excess_q       <= '0;
			last_excess_q  <= '0;
			report_count_q <= '0;
			score_q        <= '0;
			present_q      <= 1'b0;
			ev_valid_q     <= 1'b0;
			ev_kind_q      <= EV_SAMPLE_REPORT;
			ev_value_q     <= '0;
		end else if (advance) begin
			seeded_q       <= seeded_n;
			calibrated_q   <= calibrated_n;
			cal_sum_q      <= cal_sum_n;
			cal_count_q    <= cal_count_n;
			filtered_q     <= filtered_n;
			baseline_q     <= baseline_n;
			raw_hold_q     <= raw_hold_n;
			excess_q       <= excess_n;
			last_excess_q  <= last_excess_n;
			report_count_q <= report_count_n;
			score_q        <= score_n;
			present_q      <= present_n;
			ev_valid_q     <= ev_valid_n;
			ev_kind_q      <= ev_kind_n;
			ev_value_q     <= ev_value_n;
		end
	end

	// result transaction
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {ev_kind_q, ev_valid_q};
	assign m_tdata  = {4'b0, calibrated_q, present_q, score_q, excess_q, baseline_q,
	                   filtered_q, raw_hold_q, ev_value_q};

	// input register must not take a new item while both stages are blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && m_tvalid_q && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline blocked");

	// a detected event always leaves presence set
	a_detect_sets_present: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_q && ev_kind_q == EV_DETECTED |-> present_q)
		else $error("detected event without presence");

	// presence only after calibration
	a_present_needs_cal: assert property (@(posedge clk) disable iff (!arst_n)
		present_q |-> calibrated_q)
		else $error("presence before calibration");

	// calibration end posts a sample report carrying the baseline
	a_cal_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(calibrated_q) |-> ev_valid_q && ev_kind_q == EV_SAMPLE_REPORT
			&& ev_value_q == baseline_q)
		else $error("calibration end without baseline report");

endmodule
